/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/cna_pkg.sv */
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cna_pkg;

    localparam int CNA_DATA_WIDTH = 32;
    localparam int CNA_FRAC_BITS  = 16;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_NEG = 3'd5
    } t_op;

    // Packed with is_equal in the lowest bit.
    typedef struct packed {
        logic overflowed;
        logic div_zero;
        logic is_equal;
    } t_flags;

    localparam int CNA_FLAGS_W = $bits(t_flags);

    typedef struct packed {
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic sat_re;
        logic sat_im;
    } t_div_ctl;

endpackage

/* hw/rtl/complex_number_alu.sv */
// Throughput: one item per cycle while the output skid entry is free; the
// multipliers and divider lanes are fully pipelined.
// The divide path sets the depth: one quotient bit per stage, DATA_WIDTH stages.
// Reset: i_rst_n is synchronous and active low; it empties the pipeline and output buffer.
// ----------------------------------------------------------------------------
// complex_number_alu
// Pipelined complex arithmetic unit on signed fixed-point operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_number_alu #(
    parameter int DATA_WIDTH = cna_pkg::CNA_DATA_WIDTH,
    parameter int FRAC_BITS  = cna_pkg::CNA_FRAC_BITS,
    localparam int IN_TDATA_W  = ((4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input item.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // a_real, a_imag, b_real, b_imag (lowest bit first)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [2:0]             s_axis_tuser,
    // Result item.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // res_real, res_imag (lowest bit first)
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // is_equal, div_zero, overflowed (lowest bit first)
    output logic [cna_pkg::CNA_FLAGS_W-1:0] m_axis_tuser
);
    import cna_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    // Four front stages, one stage per quotient bit, one result stage.
    localparam int P  = 4 + W + 1;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // The whole pipeline advances together. It is parted from the output by
    // a two-entry buffer, so it only stops when both entries hold results
    // that the consumer has not yet taken.
    logic         w_en;
    logic [P-1:0] r_valid;
    logic         r_out_v, r_skid_v;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[P-2:0], s_axis_tvalid};
        end
    end

    // Operand unpacking.
    t_op                 w_op;
    logic signed [W-1:0] w_ar, w_ai, w_br, w_bi;

    assign w_op = t_op'(s_axis_tuser);
    assign w_ar = s_axis_tdata[W-1:0];
    assign w_ai = s_axis_tdata[2*W-1:W];
    assign w_br = s_axis_tdata[3*W-1:2*W];
    assign w_bi = s_axis_tdata[4*W-1:3*W];

    // Front stages: products, sums, scaling and the quotient range check.
    t_div_ctl      w_f_ctl;
    t_flags        w_f_flags;
    logic [W-1:0]  w_f_res_re, w_f_res_im, w_f_low_re, w_f_low_im;
    logic [PW-1:0] w_f_rem_re, w_f_rem_im, w_f_den;

    cna_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_op     (w_op),
        .i_ar     (w_ar),
        .i_ai     (w_ai),
        .i_br     (w_br),
        .i_bi     (w_bi),
        .o_ctl    (w_f_ctl),
        .o_flags  (w_f_flags),
        .o_res_re (w_f_res_re),
        .o_res_im (w_f_res_im),
        .o_rem_re (w_f_rem_re),
        .o_rem_im (w_f_rem_im),
        .o_low_re (w_f_low_re),
        .o_low_im (w_f_low_im),
        .o_den    (w_f_den)
    );

    // Two divider lanes, one for each quotient part. Every item passes
    // through them, whatever its operation, so the order is kept.
    logic [W-1:0] w_q_re, w_q_im;

    cna_div_lane #(.DATA_WIDTH(DATA_WIDTH)) u_div_re (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_f_rem_re),
        .i_low (w_f_low_re),
        .i_den (w_f_den),
        .o_quo (w_q_re)
    );

    cna_div_lane #(.DATA_WIDTH(DATA_WIDTH)) u_div_im (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_f_rem_im),
        .i_low (w_f_low_im),
        .i_den (w_f_den),
        .o_quo (w_q_im)
    );

    // Side band that travels alongside the divider lanes.
    t_div_ctl     r_sb_ctl    [W];
    t_flags       r_sb_flags  [W];
    logic [W-1:0] r_sb_res_re [W];
    logic [W-1:0] r_sb_res_im [W];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_ctl[0]    <= w_f_ctl;
            r_sb_flags[0]  <= w_f_flags;
            r_sb_res_re[0] <= w_f_res_re;
            r_sb_res_im[0] <= w_f_res_im;
            for (int k = 1; k < W; k++) begin
                r_sb_ctl[k]    <= r_sb_ctl[k-1];
                r_sb_flags[k]  <= r_sb_flags[k-1];
                r_sb_res_re[k] <= r_sb_res_re[k-1];
                r_sb_res_im[k] <= r_sb_res_im[k-1];
            end
        end
    end

    // Result stage: sign and saturation of the quotients, and the final
    // choice between the divide result and the one computed up front.
    // A quotient magnitude is below 2^DATA_WIDTH here; larger ones were
    // caught by the range check and arrive with their saturate bit set.
    t_div_ctl     w_c;
    logic [W-1:0] w_d_re, w_d_im;
    logic         w_dov_re, w_dov_im;
    logic [W-1:0] r_fin_re, r_fin_im;
    t_flags       r_fin_flags;

    assign w_c = r_sb_ctl[W-1];

    always_comb begin
        w_dov_re = 1'b1;
        w_dov_im = 1'b1;
        if (w_c.sat_re) begin
            w_d_re = w_c.neg_re ? MINV : MAXV;
        end else if (w_c.neg_re) begin
            w_dov_re = (w_q_re > MINV);
            w_d_re   = w_dov_re ? MINV : (~w_q_re + W'(1));
        end else begin
            w_dov_re = w_q_re[W-1];
            w_d_re   = w_dov_re ? MAXV : w_q_re;
        end
        if (w_c.sat_im) begin
            w_d_im = w_c.neg_im ? MINV : MAXV;
        end else if (w_c.neg_im) begin
            w_dov_im = (w_q_im > MINV);
            w_d_im   = w_dov_im ? MINV : (~w_q_im + W'(1));
        end else begin
            w_dov_im = w_q_im[W-1];
            w_d_im   = w_dov_im ? MAXV : w_q_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!w_c.is_div) begin
                r_fin_re    <= r_sb_res_re[W-1];
                r_fin_im    <= r_sb_res_im[W-1];
                r_fin_flags <= r_sb_flags[W-1];
            end else if (w_c.dz) begin
                // Zero divisor: zero result, flagged, no overflow.
                r_fin_re               <= '0;
                r_fin_im               <= '0;
                r_fin_flags.is_equal   <= 1'b0;
                r_fin_flags.div_zero   <= 1'b1;
                r_fin_flags.overflowed <= 1'b0;
            end else begin
                r_fin_re               <= w_d_re;
                r_fin_im               <= w_d_im;
                r_fin_flags.is_equal   <= 1'b0;
                r_fin_flags.div_zero   <= 1'b0;
                r_fin_flags.overflowed <= w_dov_re | w_dov_im;
            end
        end
    end

    // Output buffer: the output register plus one skid entry. A result
    // leaves the pipeline whenever the skid entry is free; it goes straight
    // to the output register when that one is empty or being taken.
    logic         w_pipe_v;
    logic [W-1:0] r_out_re, r_out_im, r_skid_re, r_skid_im;
    t_flags       r_out_flags, r_skid_flags;

    assign w_pipe_v = r_valid[P-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_pipe_v) begin
            if (!r_out_v || m_axis_tready) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out_re    <= r_skid_re;
                r_out_im    <= r_skid_im;
                r_out_flags <= r_skid_flags;
            end
        end else if (w_pipe_v) begin
            if (!r_out_v || m_axis_tready) begin
                r_out_re    <= r_fin_re;
                r_out_im    <= r_fin_im;
                r_out_flags <= r_fin_flags;
            end else begin
                r_skid_re    <= r_fin_re;
                r_skid_im    <= r_fin_im;
                r_skid_flags <= r_fin_flags;
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_im, r_out_re});
    assign m_axis_tuser  = r_out_flags;

endmodule

/* hw/rtl/cna_front.sv */
// ----------------------------------------------------------------------------
// cna_front
// Four front stages: products, sums, scaling/magnitude, divide range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cna_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  cna_pkg::t_op                  i_op,
    input  logic signed [DATA_WIDTH-1:0]  i_ar,
    input  logic signed [DATA_WIDTH-1:0]  i_ai,
    input  logic signed [DATA_WIDTH-1:0]  i_br,
    input  logic signed [DATA_WIDTH-1:0]  i_bi,
    output cna_pkg::t_div_ctl             o_ctl,
    output cna_pkg::t_flags               o_flags,
    output logic [DATA_WIDTH-1:0]         o_res_re,
    output logic [DATA_WIDTH-1:0]         o_res_im,
    output logic [2*DATA_WIDTH-1:0]       o_rem_re,
    output logic [2*DATA_WIDTH-1:0]       o_rem_im,
    output logic [DATA_WIDTH-1:0]         o_low_re,
    output logic [DATA_WIDTH-1:0]         o_low_im,
    output logic [2*DATA_WIDTH-1:0]       o_den
);
    import cna_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = SW + F;
    localparam int HW = NW - W;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // Stage 1: products, linear operations and the equality test.
    logic signed [W:0]    w_ar_x, w_ai_x, w_br_x, w_bi_x;
    logic signed [W:0]    n_lin_re, n_lin_im;
    logic signed [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_sr, r1_p_si;
    logic signed [W:0]    r1_lin_re, r1_lin_im;
    t_op                  r1_op;
    logic                 r1_eq;

    assign w_ar_x = {i_ar[W-1], i_ar};
    assign w_ai_x = {i_ai[W-1], i_ai};
    assign w_br_x = {i_br[W-1], i_br};
    assign w_bi_x = {i_bi[W-1], i_bi};

    always_comb begin
        unique case (i_op)
            OP_ADD: begin
                n_lin_re = w_ar_x + w_br_x;
                n_lin_im = w_ai_x + w_bi_x;
            end
            OP_SUB: begin
                n_lin_re = w_ar_x - w_br_x;
                n_lin_im = w_ai_x - w_bi_x;
            end
            OP_NEG: begin
                n_lin_re = -w_ar_x;
                n_lin_im = -w_ai_x;
            end
            default: begin
                n_lin_re = '0;
                n_lin_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p_rr   <= i_ar * i_br;
            r1_p_ii   <= i_ai * i_bi;
            r1_p_ri   <= i_ar * i_bi;
            r1_p_ir   <= i_ai * i_br;
            r1_p_sr   <= i_br * i_br;
            r1_p_si   <= i_bi * i_bi;
            r1_lin_re <= n_lin_re;
            r1_lin_im <= n_lin_im;
            r1_op     <= i_op;
            r1_eq     <= (i_op == OP_EQ) && (i_ar == i_br) && (i_ai == i_bi);
        end
    end

    // Stage 2: sums of products, divisor magnitude, linear saturation.
    logic signed [SW-1:0] n_x_re, n_x_im;
    logic [PW-1:0]        n_den;
    logic                 w_lin_ov_re, w_lin_ov_im;
    logic signed [SW-1:0] r2_x_re, r2_x_im;
    logic [PW-1:0]        r2_den;
    logic [W-1:0]         r2_lin_re, r2_lin_im;
    logic                 r2_lin_ov;
    t_op                  r2_op;
    logic                 r2_eq;

    always_comb begin
        if (r1_op == OP_MUL) begin
            n_x_re = r1_p_rr - r1_p_ii;
            n_x_im = r1_p_ri + r1_p_ir;
        end else begin
            n_x_re = r1_p_rr + r1_p_ii;
            n_x_im = r1_p_ir - r1_p_ri;
        end
    end

    assign n_den       = r1_p_sr[PW-1:0] + r1_p_si[PW-1:0];
    assign w_lin_ov_re = r1_lin_re[W] ^ r1_lin_re[W-1];
    assign w_lin_ov_im = r1_lin_im[W] ^ r1_lin_im[W-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x_re   <= n_x_re;
            r2_x_im   <= n_x_im;
            r2_den    <= n_den;
            r2_lin_re <= w_lin_ov_re ? (r1_lin_re[W] ? MINV : MAXV) : r1_lin_re[W-1:0];
            r2_lin_im <= w_lin_ov_im ? (r1_lin_im[W] ? MINV : MAXV) : r1_lin_im[W-1:0];
            r2_lin_ov <= w_lin_ov_re | w_lin_ov_im;
            r2_op     <= r1_op;
            r2_eq     <= r1_eq;
        end
    end

    // Stage 3: multiply scaling and saturation, dividend magnitudes.
    logic signed [SW-1:0] w_sh_re, w_sh_im;
    logic [SW-W:0]        w_top_re, w_top_im;
    logic                 w_mov_re, w_mov_im;
    logic [SW-1:0]        w_xu_re, w_xu_im;
    logic [SW-1:0]        r3_mag_re, r3_mag_im;
    logic                 r3_neg_re, r3_neg_im;
    logic [PW-1:0]        r3_den;
    logic [W-1:0]         r3_res_re, r3_res_im;
    logic                 r3_ov;
    t_op                  r3_op;
    logic                 r3_eq;

    assign w_sh_re  = r2_x_re >>> F;
    assign w_sh_im  = r2_x_im >>> F;
    assign w_top_re = w_sh_re[SW-1:W-1];
    assign w_top_im = w_sh_im[SW-1:W-1];
    assign w_mov_re = !((&w_top_re) | ~(|w_top_re));
    assign w_mov_im = !((&w_top_im) | ~(|w_top_im));
    assign w_xu_re  = r2_x_re;
    assign w_xu_im  = r2_x_im;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mag_re <= w_xu_re[SW-1] ? (~w_xu_re + SW'(1)) : w_xu_re;
            r3_mag_im <= w_xu_im[SW-1] ? (~w_xu_im + SW'(1)) : w_xu_im;
            r3_neg_re <= w_xu_re[SW-1];
            r3_neg_im <= w_xu_im[SW-1];
            r3_den    <= r2_den;
            if (r2_op == OP_MUL) begin
                r3_res_re <= w_mov_re ? (w_sh_re[SW-1] ? MINV : MAXV) : w_sh_re[W-1:0];
                r3_res_im <= w_mov_im ? (w_sh_im[SW-1] ? MINV : MAXV) : w_sh_im[W-1:0];
                r3_ov     <= w_mov_re | w_mov_im;
            end else begin
                r3_res_re <= r2_lin_re;
                r3_res_im <= r2_lin_im;
                r3_ov     <= r2_lin_ov;
            end
            r3_op <= r2_op;
            r3_eq <= r2_eq;
        end
    end

    // Stage 4: quotient range check, split of the scaled dividend.
    // The quotient fits in DATA_WIDTH bits exactly when the upper part of
    // the dividend is below the divisor.
    logic [NW-1:0] w_full_re, w_full_im;
    logic [HW-1:0] w_hi_re, w_hi_im;
    logic          w_dz;

    assign w_full_re = {r3_mag_re, {F{1'b0}}};
    assign w_full_im = {r3_mag_im, {F{1'b0}}};
    assign w_hi_re   = w_full_re[NW-1:W];
    assign w_hi_im   = w_full_im[NW-1:W];
    assign w_dz      = (r3_den == '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.is_div       <= (r3_op == OP_DIV);
            o_ctl.dz           <= w_dz;
            o_ctl.neg_re       <= r3_neg_re;
            o_ctl.neg_im       <= r3_neg_im;
            o_ctl.sat_re       <= !w_dz && (w_hi_re >= r3_den);
            o_ctl.sat_im       <= !w_dz && (w_hi_im >= r3_den);
            o_flags.is_equal   <= r3_eq;
            o_flags.div_zero   <= 1'b0;
            o_flags.overflowed <= r3_ov;
            o_res_re           <= r3_res_re;
            o_res_im           <= r3_res_im;
            o_rem_re           <= PW'(w_hi_re);
            o_rem_im           <= PW'(w_hi_im);
            o_low_re           <= w_full_re[W-1:0];
            o_low_im           <= w_full_im[W-1:0];
            o_den              <= r3_den;
        end
    end

endmodule

/* hw/rtl/cna_div_lane.sv */
// ----------------------------------------------------------------------------
// cna_div_lane
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cna_div_lane #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [2*DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0]   i_low,
    input  logic [2*DATA_WIDTH-1:0] i_den,
    output logic [DATA_WIDTH-1:0]   o_quo
);
    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;

    logic [PW-1:0] r_rem [W];
    logic [W-1:0]  r_low [W];
    logic [PW-1:0] r_den [W];
    logic [W-1:0]  r_quo [W];

    for (genvar j = 0; j < W; j++) begin : g_stage
        logic [PW-1:0] s_rem, s_den;
        logic [W-1:0]  s_low, s_quo;
        logic [PW:0]   s_trial;
        logic          s_take;

        if (j == 0) begin : g_first
            assign s_rem = i_rem;
            assign s_low = i_low;
            assign s_den = i_den;
            assign s_quo = '0;
        end else begin : g_next
            assign s_rem = r_rem[j-1];
            assign s_low = r_low[j-1];
            assign s_den = r_den[j-1];
            assign s_quo = r_quo[j-1];
        end

        assign s_trial = {s_rem, s_low[W-1]};
        assign s_take  = (s_trial >= {1'b0, s_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= s_take ? PW'(s_trial - {1'b0, s_den}) : s_trial[PW-1:0];
                r_low[j] <= s_low << 1;
                r_den[j] <= s_den;
                r_quo[j] <= {s_quo[W-2:0], s_take};
            end
        end
    end

    assign o_quo = r_quo[W-1];

endmodule

/* hw/rtl/cna_checker.sv */
// ----------------------------------------------------------------------------
// cna_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cna_checker #(
    parameter int DATA_WIDTH = 32,
    localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [cna_pkg::CNA_FLAGS_W-1:0] m_axis_tuser
);
    import cna_pkg::*;

    t_flags w_fl;

    assign w_fl = m_axis_tuser;

    // A waiting item stays and does not change.
    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A zero divisor gives a zero result without overflow or equality.
    `ASSERT_IMPL(a_dz_zero, i_clk, i_rst_n, m_axis_tvalid && w_fl.div_zero, (m_axis_tdata == '0) && !w_fl.overflowed && !w_fl.is_equal)

    // An equality test gives a zero result without overflow.
    `ASSERT_IMPL(a_eq_zero, i_clk, i_rst_n, m_axis_tvalid && w_fl.is_equal, (m_axis_tdata == '0) && !w_fl.overflowed)

endmodule

bind complex_number_alu cna_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cna_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
